// File: src/bbcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbcg_pkg: shared types for the backfill byte credit gate
// Item kinds, configuration register indexes and the result flag group.
// ----------------------------------------------------------------------------
package bbcg_pkg;

    // item kind carried on the input side band
    typedef enum logic [1:0] {
        KIND_READ       = 2'd0,
        KIND_SENT       = 2'd1,
        KIND_SCAN_RESET = 2'd2
    } kind_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCAN_BYTE_LIMIT   = 2'd0,
        CFG_SCAN_ITEM_LIMIT   = 2'd1,
        CFG_BUFFER_BYTE_LIMIT = 2'd2
    } cfg_idx_t;

    // reset values of the configuration registers
    localparam logic [31:0] SCAN_BYTE_LIMIT_RST   = 32'd131072;
    localparam logic [31:0] SCAN_ITEM_LIMIT_RST   = 32'd4096;
    localparam logic [31:0] BUFFER_BYTE_LIMIT_RST = 32'd20972856;

    // result flags of one item
    typedef struct packed {
        logic wake;
        logic buffer_full;
        logic sent_error;
        logic accepted;
    } result_t;

endpackage

`default_nettype wire

// File: src/backfill_byte_credit_gate.sv
`timescale 1ns / 1ps
`default_nettype none
// One item per cycle: an input register takes an item, the credit checks and
// state update run as combinational adds and compares, and the result lands
// in an output register, from which it is offered.
// The rate is set by the single update path on the scan and buffer counters;
// the input register keeps taking items while the output register is drained,
// and only a result left waiting on the output stalls the input side.
// ----------------------------------------------------------------------------
// backfill_byte_credit_gate: two-level byte credit gate with hysteresis
// Grants read requests against per-scan byte and item budgets and a shared buffer budget,
// returns credit on sent events and raises a wake pulse when a full buffer
// drains below three quarters with room for the deferred request.
// ----------------------------------------------------------------------------
module backfill_byte_credit_gate (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] byte_count
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] accepted, [1] sent_error,
                                        // [2] buffer_full, [3] wake, [7:4] zero
);
    import bbcg_pkg::*;

    // configuration registers
    logic [31:0] scan_byte_limit_reg;
    logic [31:0] scan_item_limit_reg;
    logic [31:0] buffer_byte_limit_reg;

    // credit state
    logic [31:0] scan_bytes_reg,   scan_bytes_next;
    logic [31:0] scan_items_reg,   scan_items_next;
    logic [31:0] held_bytes_reg,   held_bytes_next;
    logic [31:0] pending_size_reg, pending_size_next;
    logic        full_flag_reg,    full_flag_next;

    // input register
    logic        in_valid_reg;
    kind_t       kind_reg;
    logic [31:0] count_reg;

    // output register
    logic        out_valid_reg;
    result_t     result_reg, result_next;

    logic        advance;

    // check terms
    logic [32:0] scan_sum;
    logic [32:0] held_sum;
    logic        item_ok;
    logic        scan_ok;
    logic        buf_ok;
    logic        sent_err;
    logic [31:0] held_sub;
    logic [33:0] limit_x3;
    logic [31:0] threshold;
    logic        fits;
    logic        cleared;

    // handshake: item moves to the output when that register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, result_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_byte_limit_reg   <= SCAN_BYTE_LIMIT_RST;
            scan_item_limit_reg   <= SCAN_ITEM_LIMIT_RST;
            buffer_byte_limit_reg <= BUFFER_BYTE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SCAN_BYTE_LIMIT:   scan_byte_limit_reg   <= cfg_data;
                CFG_SCAN_ITEM_LIMIT:   scan_item_limit_reg   <= cfg_data;
                CFG_BUFFER_BYTE_LIMIT: buffer_byte_limit_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // widened sums and budget compares
    always_comb
    begin
        scan_sum  = {1'b0, scan_bytes_reg} + {1'b0, count_reg};
        held_sum  = {1'b0, held_bytes_reg} + {1'b0, count_reg};
        item_ok   = scan_items_reg < scan_item_limit_reg;
        scan_ok   = (scan_sum <= {1'b0, scan_byte_limit_reg}) || (scan_bytes_reg == 32'd0);
        buf_ok    = (held_bytes_reg == 32'd0) || (held_sum <= {1'b0, buffer_byte_limit_reg});
        sent_err  = count_reg > held_bytes_reg;
        held_sub  = held_bytes_reg - count_reg;
        limit_x3  = {2'b00, buffer_byte_limit_reg} + {1'b0, buffer_byte_limit_reg, 1'b0};
        threshold = limit_x3[33:2];
        fits      = (held_sub <= buffer_byte_limit_reg)
                    && ((buffer_byte_limit_reg - held_sub) >= pending_size_reg);
        cleared   = held_sub < threshold;
    end

    // next state and result for the item in the input register
    always_comb
    begin
        scan_bytes_next   = scan_bytes_reg;
        scan_items_next   = scan_items_reg;
        held_bytes_next   = held_bytes_reg;
        pending_size_next = pending_size_reg;
        full_flag_next    = full_flag_reg;
        result_next       = '0;
        case (kind_reg)
            KIND_READ:
            begin
                if (item_ok && scan_ok)
                begin
                    if (buf_ok)
                    begin
                        scan_bytes_next       = scan_sum[31:0];
                        held_bytes_next       = held_sum[31:0];
                        scan_items_next       = scan_items_reg + 32'd1;
                        result_next.accepted  = 1'b1;
                    end
                    else
                    begin
                        // buffer refusal: remember the size, mark full
                        full_flag_next    = 1'b1;
                        pending_size_next = count_reg;
                    end
                end
            end
            KIND_SENT:
            begin
                if (sent_err)
                begin
                    result_next.sent_error = 1'b1;
                end
                else
                begin
                    held_bytes_next = held_sub;
                    if (full_flag_reg && fits && cleared)
                    begin
                        pending_size_next = 32'd0;
                        full_flag_next    = 1'b0;
                        result_next.wake  = 1'b1;
                    end
                end
            end
            KIND_SCAN_RESET:
            begin
                scan_bytes_next = 32'd0;
                scan_items_next = 32'd0;
            end
            default:
            begin
            end
        endcase
        result_next.buffer_full = full_flag_next;
    end

    // control and credit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            scan_bytes_reg   <= '0;
            scan_items_reg   <= '0;
            held_bytes_reg   <= '0;
            pending_size_reg <= '0;
            full_flag_reg    <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                scan_bytes_reg   <= scan_bytes_next;
                scan_items_reg   <= scan_items_next;
                held_bytes_reg   <= held_bytes_next;
                pending_size_reg <= pending_size_next;
                full_flag_reg    <= full_flag_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg  <= kind_t'(s_tuser);
            count_reg <= s_tdata;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // a wake pulse always reports the buffer as no longer full
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.wake && result_reg.buffer_full))
        else $error("wake with buffer_full set");

    // grant and sent error never come from the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.accepted && result_reg.sent_error))
        else $error("accepted and sent_error together");

    // reported full flag matches the committed state
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_reg.buffer_full == full_flag_reg))
        else $error("buffer_full differs from full flag");

    // a sent error leaves the held byte count untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (kind_reg == KIND_SENT) && sent_err) |=> $stable(held_bytes_reg))
        else $error("held bytes changed on sent error");

    // the full flag only clears with a wake pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(full_flag_reg) |-> result_reg.wake)
        else $error("full flag cleared without wake");

endmodule

`default_nettype wire
